>>> design/cursor_text_buffer_editor_core_defines.svh
// Assertion macros for the cursor text buffer editor core.
`ifndef CURSOR_TEXT_BUFFER_EDITOR_CORE_DEFINES_SVH
`define CURSOR_TEXT_BUFFER_EDITOR_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on every clock edge out of reset.
`define CTBE_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked on every clock edge out of reset.
`define CTBE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CTBE_ASSERT_IMPL(lbl, ante, cons, msg)
`define CTBE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> design/ctbe_pkg.sv
// Shared types and constants for the cursor text buffer editor.
package ctbe_pkg;

    localparam int ACTION_W = 3;
    localparam int COUNT_W  = 8;
    localparam int BYTE_W   = 8;
    localparam int PEEK_W   = 10;
    localparam int CURSOR_W = 11;

    localparam logic [BYTE_W-1:0] SPACE_BYTE = 8'h20;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INSERT  = 3'd0,
        ACT_DELETE  = 3'd1,
        ACT_SWAP    = 3'd2,
        ACT_ADVANCE = 3'd3,
        ACT_BACKUP  = 3'd4,
        ACT_READ    = 3'd5
    } action_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic clear_wr;
        logic ins_step;
        logic del_step;
        logic move;
        logic swap_chk;
        logic swap_rd;
        logic swap_wr_lo;
        logic swap_wr_hi;
        logic peek_rd;
        logic finish;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic clear_last;
        logic ins_done;
        logic del_done;
        logic swap_ok;
    } status_t;

endpackage

>>> design/cursor_text_buffer_editor_core.sv
// Top level of the cursor text buffer editor: controller plus datapath.
// Insert and delete step through INS or DEL (one memory write per cycle), then FINISH;
// advance and backup go through MOVE, read through PEEK, a swap clipped at the end through
// SWAP, a swap through SWAP, SW_RD, SW_WR0 and SW_WR1, unused codes straight to FINISH. The
// result is valid in the cycle in_ready rises; one still in the output register holds the
// next in FINISH. After reset a clearing pass zeroes all BUFFER_BYTES entries, in_ready low.
`include "cursor_text_buffer_editor_core_defines.svh"

module cursor_text_buffer_editor_core #(
    parameter int BUFFER_BYTES = 1024
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [ctbe_pkg::ACTION_W-1:0]  action,
    input  logic [ctbe_pkg::COUNT_W-1:0]   count,
    input  logic [ctbe_pkg::BYTE_W-1:0]    value,
    input  logic [ctbe_pkg::PEEK_W-1:0]    peek_index,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [ctbe_pkg::CURSOR_W-1:0]  cursor,
    output logic [ctbe_pkg::BYTE_W-1:0]    peek_byte,
    output logic                           error
);
    import ctbe_pkg::*;

    cmd_t    cmd;
    status_t status;

    ctbe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .action    (action),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    ctbe_datapath #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .action     (action),
        .count      (count),
        .value      (value),
        .peek_index (peek_index),
        .status     (status),
        .cursor     (cursor),
        .peek_byte  (peek_byte),
        .error      (error)
    );

    // one instruction at a time: busy right after a transfer in
    `CTBE_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "accepted while busy")
    // a nonzero peeked byte never comes with an error
    `CTBE_ASSERT_IMPL(a_peek_no_err, out_valid && (peek_byte != '0), !error, "peek byte with error")
    // reported cursor stays inside the buffer
    `CTBE_ASSERT_IMPL(a_cursor_range, out_valid, 32'(cursor) <= BUFFER_BYTES, "cursor out of range")

endmodule

>>> design/ctbe_ctrl.sv
// Controller state machine: sequences clear, edit steps and the result transfer.
module ctbe_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [ctbe_pkg::ACTION_W-1:0]  action,
    output logic                           out_valid,
    input  logic                           out_ready,
    input  ctbe_pkg::status_t              status,
    output ctbe_pkg::cmd_t                 cmd
);
    import ctbe_pkg::*;

    typedef enum logic [10:0] {
        ST_CLEAR  = 11'b000_0000_0001,
        ST_IDLE   = 11'b000_0000_0010,
        ST_INS    = 11'b000_0000_0100,
        ST_DEL    = 11'b000_0000_1000,
        ST_MOVE   = 11'b000_0001_0000,
        ST_SWAP   = 11'b000_0010_0000,
        ST_SW_RD  = 11'b000_0100_0000,
        ST_SW_WR0 = 11'b000_1000_0000,
        ST_SW_WR1 = 11'b001_0000_0000,
        ST_PEEK   = 11'b010_0000_0000,
        ST_FINISH = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    // Next state and command decode
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    case (action)
                        ACT_INSERT:              state_next = ST_INS;
                        ACT_DELETE:              state_next = ST_DEL;
                        ACT_SWAP:                state_next = ST_SWAP;
                        ACT_ADVANCE, ACT_BACKUP: state_next = ST_MOVE;
                        ACT_READ:                state_next = ST_PEEK;
                        default:                 state_next = ST_FINISH;
                    endcase
                end
            end
            ST_INS:
            begin
                cmd.ins_step = 1'b1;
                if (status.ins_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_DEL:
            begin
                cmd.del_step = 1'b1;
                if (status.del_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_MOVE:
            begin
                cmd.move   = 1'b1;
                state_next = ST_FINISH;
            end
            ST_SWAP:
            begin
                cmd.swap_chk = 1'b1;
                state_next   = status.swap_ok ? ST_SW_RD : ST_FINISH;
            end
            ST_SW_RD:
            begin
                cmd.swap_rd = 1'b1;
                state_next  = ST_SW_WR0;
            end
            ST_SW_WR0:
            begin
                cmd.swap_wr_lo = 1'b1;
                state_next     = ST_SW_WR1;
            end
            ST_SW_WR1:
            begin
                cmd.swap_wr_hi = 1'b1;
                state_next     = ST_FINISH;
            end
            ST_PEEK:
            begin
                cmd.peek_rd = 1'b1;
                state_next  = ST_FINISH;
            end
            ST_FINISH:
            begin
                // load the output register once it is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid flag
    always_comb
    begin
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> design/ctbe_datapath.sv
// Datapath: text memory, cursor, operand registers and the result register.
module ctbe_datapath #(
    parameter int BUFFER_BYTES = 1024
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  ctbe_pkg::cmd_t                 cmd,
    input  logic [ctbe_pkg::ACTION_W-1:0]  action,
    input  logic [ctbe_pkg::COUNT_W-1:0]   count,
    input  logic [ctbe_pkg::BYTE_W-1:0]    value,
    input  logic [ctbe_pkg::PEEK_W-1:0]    peek_index,
    output ctbe_pkg::status_t              status,
    output logic [ctbe_pkg::CURSOR_W-1:0]  cursor,
    output logic [ctbe_pkg::BYTE_W-1:0]    peek_byte,
    output logic                           error
);
    import ctbe_pkg::*;

    localparam int AW  = $clog2(BUFFER_BYTES);
    localparam int CW  = $clog2(BUFFER_BYTES + 1);
    localparam int XW  = ((CW > COUNT_W) ? CW : COUNT_W) + 1;
    localparam int PKW = ((AW > PEEK_W) ? AW : PEEK_W) + 1;

    // control state
    logic [CW-1:0]       cursor_reg, cursor_next;
    logic [AW-1:0]       clr_addr_reg;

    // operand and result payload
    logic [ACTION_W-1:0] act_reg;
    logic [COUNT_W-1:0]  cnt_reg;
    logic [BYTE_W-1:0]   val_reg;
    logic [PEEK_W-1:0]   pidx_reg;
    logic                err_reg;
    logic [BYTE_W-1:0]   tmp_reg;
    logic [BYTE_W-1:0]   rd_data_reg;
    logic [CURSOR_W-1:0] cursor_out_reg;
    logic [BYTE_W-1:0]   peek_out_reg;
    logic                err_out_reg;

    logic [BYTE_W-1:0]   mem [BUFFER_BYTES];

    logic                at_end, at_start, cnt_zero, ins_done, del_done;
    logic                swap_ok, peek_ok, adv_clip, bak_clip;
    logic [CW-1:0]       cursor_inc, cursor_dec;
    logic [XW-1:0]       room;
    logic                ins_wr, del_wr, wr_en, rd_en;
    logic [AW-1:0]       wr_addr, rd_addr;
    logic [BYTE_W-1:0]   wr_data;

    // Edge and clip checks
    assign at_end     = (cursor_reg == CW'(BUFFER_BYTES));
    assign at_start   = (cursor_reg == '0);
    assign cnt_zero   = (cnt_reg == '0);
    assign ins_done   = cnt_zero || at_end;
    assign del_done   = cnt_zero || at_start;
    assign swap_ok    = (cursor_reg < CW'(BUFFER_BYTES - 1));
    assign peek_ok    = (PKW'(pidx_reg) < PKW'(BUFFER_BYTES));
    assign cursor_inc = cursor_reg + CW'(1);
    assign cursor_dec = cursor_reg - CW'(1);
    assign room       = XW'(BUFFER_BYTES) - XW'(cursor_reg);
    assign adv_clip   = (XW'(cnt_reg) > room);
    assign bak_clip   = (XW'(cnt_reg) > XW'(cursor_reg));
    assign ins_wr     = cmd.ins_step && !ins_done;
    assign del_wr     = cmd.del_step && !del_done;

    assign status.clear_last = (clr_addr_reg == AW'(BUFFER_BYTES - 1));
    assign status.ins_done   = ins_done;
    assign status.del_done   = del_done;
    assign status.swap_ok    = swap_ok;

    // Memory write port select
    always_comb
    begin
        wr_en   = 1'b1;
        wr_addr = AW'(cursor_reg);
        wr_data = val_reg;
        if (cmd.clear_wr)
        begin
            wr_addr = clr_addr_reg;
            wr_data = '0;
        end
        else if (ins_wr)
        begin
            wr_addr = AW'(cursor_reg);
            wr_data = val_reg;
        end
        else if (del_wr)
        begin
            wr_addr = AW'(cursor_dec);
            wr_data = SPACE_BYTE;
        end
        else if (cmd.swap_wr_lo)
        begin
            wr_addr = AW'(cursor_reg);
            wr_data = rd_data_reg;
        end
        else if (cmd.swap_wr_hi)
        begin
            wr_addr = AW'(cursor_inc);
            wr_data = tmp_reg;
        end
        else
        begin
            wr_en = 1'b0;
        end
    end

    // Memory read port select
    always_comb
    begin
        rd_en   = 1'b1;
        rd_addr = AW'(cursor_reg);
        if (cmd.swap_chk && swap_ok)
        begin
            rd_addr = AW'(cursor_reg);
        end
        else if (cmd.swap_rd)
        begin
            rd_addr = AW'(cursor_inc);
        end
        else if (cmd.peek_rd && peek_ok)
        begin
            rd_addr = AW'(pidx_reg);
        end
        else
        begin
            rd_en = 1'b0;
        end
    end

    // Text memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Cursor update
    always_comb
    begin
        cursor_next = cursor_reg;
        if (ins_wr || cmd.swap_wr_hi)
        begin
            cursor_next = cursor_inc;
        end
        else if (del_wr)
        begin
            cursor_next = cursor_dec;
        end
        else if (cmd.move)
        begin
            if (act_reg == ACT_ADVANCE)
            begin
                cursor_next = adv_clip ? CW'(BUFFER_BYTES) : cursor_reg + CW'(cnt_reg);
            end
            else
            begin
                cursor_next = bak_clip ? '0 : cursor_reg - CW'(cnt_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg   <= '0;
            clr_addr_reg <= '0;
        end
        else
        begin
            cursor_reg <= cursor_next;
            if (cmd.clear_wr)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
        end
    end

    // Operand capture, repeat count and error flag
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg  <= action;
            cnt_reg  <= count;
            val_reg  <= value;
            pidx_reg <= peek_index;
            err_reg  <= 1'b0;
        end
        else
        begin
            if (ins_wr || del_wr)
            begin
                cnt_reg <= cnt_reg - COUNT_W'(1);
            end
            if ((cmd.ins_step && !cnt_zero && at_end) ||
                (cmd.del_step && !cnt_zero && at_start) ||
                (cmd.move && (act_reg == ACT_ADVANCE) && adv_clip) ||
                (cmd.move && (act_reg == ACT_BACKUP) && bak_clip) ||
                (cmd.swap_chk && !swap_ok) ||
                (cmd.peek_rd && !peek_ok))
            begin
                err_reg <= 1'b1;
            end
        end
        if (cmd.swap_rd)
        begin
            tmp_reg <= rd_data_reg;
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            cursor_out_reg <= CURSOR_W'(cursor_reg);
            peek_out_reg   <= ((act_reg == ACT_READ) && !err_reg) ? rd_data_reg : '0;
            err_out_reg    <= err_reg;
        end
    end

    assign cursor    = cursor_out_reg;
    assign peek_byte = peek_out_reg;
    assign error     = err_out_reg;

endmodule

>>> verif/cursor_text_buffer_editor_core_tb.sv
// Self-checking testbench for the cursor text buffer editor core.
module cursor_text_buffer_editor_core_tb;

    import ctbe_pkg::*;

    localparam int BUF_BYTES    = 1024;
    localparam int LIMIT_CYCLES = 2_000_000;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_CYCLES = 300;

    // Action codes outside the package enum; the block treats them as no-ops
    localparam logic [ACTION_W-1:0] ACT_SPARE6 = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_SPARE7 = 3'd7;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [COUNT_W-1:0]  count;
        logic [BYTE_W-1:0]   value;
        logic [PEEK_W-1:0]   peek_index;
    } edit_cmd_t;

    typedef struct packed {
        logic [CURSOR_W-1:0] cursor;
        logic [BYTE_W-1:0]   peek_byte;
        logic                error;
    } edit_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic out_ready = 1'b0;
    logic in_ready;
    logic out_valid;
    logic [CURSOR_W-1:0] cursor;
    logic [BYTE_W-1:0]   peek_byte;
    logic                error;

    edit_cmd_t cur_edit = '0;

    edit_cmd_t    pending_edits[$];
    edit_result_t expected_results[$];

    // Shadow copy of the editor state
    logic [BYTE_W-1:0] text_mem [BUF_BYTES];
    int cur_pos = 0;

    int  edits_offered = 0;
    int  edits_accepted = 0;
    int  gap_left = 0;
    int  ready_hold = 0;
    int  stall_requests = 0;
    int  stall_served = 0;
    int  fail_count = 0;
    int  cycle_count = 0;
    logic idle_on = 1'b1;

    cursor_text_buffer_editor_core DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (cur_edit.action),
        .count      (cur_edit.count),
        .value      (cur_edit.value),
        .peek_index (cur_edit.peek_index),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .cursor     (cursor),
        .peek_byte  (peek_byte),
        .error      (error)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Executes one edit on the shadow state and returns the result it should produce
    function automatic edit_result_t apply_edit(edit_cmd_t c);
        edit_result_t r;
        int k;
        logic [BYTE_W-1:0] held;
        r = '0;
        k = 0;
        case (c.action)
            ACT_INSERT:
            begin
                while (k < c.count && !r.error)
                begin
                    if (cur_pos >= BUF_BYTES)
                        r.error = 1'b1;
                    else
                    begin
                        text_mem[cur_pos] = c.value;
                        cur_pos++;
                        k++;
                    end
                end
            end
            ACT_DELETE:
            begin
                while (k < c.count && !r.error)
                begin
                    if (cur_pos == 0)
                        r.error = 1'b1;
                    else
                    begin
                        cur_pos--;
                        text_mem[cur_pos] = SPACE_BYTE;
                        k++;
                    end
                end
            end
            ACT_SWAP:
            begin
                if (cur_pos + 1 >= BUF_BYTES)
                    r.error = 1'b1;
                else
                begin
                    held = text_mem[cur_pos];
                    text_mem[cur_pos] = text_mem[cur_pos + 1];
                    text_mem[cur_pos + 1] = held;
                    cur_pos++;
                end
            end
            ACT_ADVANCE:
            begin
                if (c.count > BUF_BYTES - cur_pos)
                begin
                    cur_pos = BUF_BYTES;
                    r.error = 1'b1;
                end
                else
                    cur_pos += c.count;
            end
            ACT_BACKUP:
            begin
                if (c.count > cur_pos)
                begin
                    cur_pos = 0;
                    r.error = 1'b1;
                end
                else
                    cur_pos -= c.count;
            end
            ACT_READ:
            begin
                if (c.peek_index < BUF_BYTES)
                    r.peek_byte = text_mem[c.peek_index];
                else
                    r.error = 1'b1;
            end
            default:
            begin
            end
        endcase
        r.cursor = cur_pos[CURSOR_W-1:0];
        return r;
    endfunction

    // Mostly short gaps, a few long ones; none when idling is off
    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on)
            return 0;
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic push_edit(input logic [ACTION_W-1:0] a, input int n, input int v,
                             input int idx);
        edit_cmd_t c;
        c.action     = a;
        c.count      = n[COUNT_W-1:0];
        c.value      = v[BYTE_W-1:0];
        c.peek_index = idx[PEEK_W-1:0];
        pending_edits.push_back(c);
    endtask

    // Random edit: mostly small counts so the cursor wanders, with long moves
    // now and then to hit both edges
    task automatic push_random_edit();
        int sel;
        int n;
        int idx;
        logic [ACTION_W-1:0] a;
        sel = $urandom_range(0, 99);
        if (sel < 22)
            a = ACT_INSERT;
        else if (sel < 40)
            a = ACT_DELETE;
        else if (sel < 52)
            a = ACT_SWAP;
        else if (sel < 66)
            a = ACT_ADVANCE;
        else if (sel < 78)
            a = ACT_BACKUP;
        else if (sel < 96)
            a = ACT_READ;
        else if (sel < 98)
            a = ACT_SPARE6;
        else
            a = ACT_SPARE7;
        sel = $urandom_range(0, 99);
        if (sel < 80)
            n = $urandom_range(0, 12);
        else if (sel < 95)
            n = $urandom_range(13, 255);
        else
            n = 255;
        // Reads land near the cursor half the time
        if ($urandom_range(0, 1) == 0)
            idx = (cur_pos + $urandom_range(0, 16) - 8) & (BUF_BYTES - 1);
        else
            idx = $urandom_range(0, BUF_BYTES - 1);
        push_edit(a, n, $urandom_range(0, 255), idx);
    endtask

    task automatic wait_drained();
        while (pending_edits.size() != 0 || edits_offered != edits_accepted
               || expected_results.size() != 0)
            @(posedge clk);
    endtask

    // Driver: offers queued edits, holds each until its transfer
    always @(negedge clk)
    begin
        if (in_valid && edits_offered == edits_accepted)
            gap_left = draw_gap();
        if (in_valid && edits_offered != edits_accepted)
        begin
        end
        else if (gap_left > 0)
        begin
            gap_left--;
            in_valid <= 1'b0;
        end
        else if (rst_n && pending_edits.size() != 0)
        begin
            cur_edit <= pending_edits.pop_front();
            in_valid <= 1'b1;
            edits_offered++;
        end
        else
            in_valid <= 1'b0;
    end

    // Input transfer: predict the result
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            expected_results.push_back(apply_edit(cur_edit));
            edits_accepted++;
        end
    end

    // Receiver back-pressure, with an occasional long hold-off on request
    always @(negedge clk)
    begin
        if (stall_served != stall_requests)
        begin
            stall_served++;
            ready_hold = LONG_HOLD;
        end
        else if (ready_hold == 0 && $urandom_range(0, 2) == 0)
            ready_hold = draw_gap();
        if (ready_hold > 0)
        begin
            ready_hold--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // Monitor: compare each result transfer with the oldest prediction
    always @(posedge clk)
    begin
        edit_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result: cursor=%0d peek_byte=%0h error=%0b",
                       cursor, peek_byte, error);
                fail_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (cursor !== want.cursor)
                begin
                    $error("cursor: expected %0d, got %0d", want.cursor, cursor);
                    fail_count++;
                end
                if (peek_byte !== want.peek_byte)
                begin
                    $error("peek_byte: expected %0h, got %0h", want.peek_byte, peek_byte);
                    fail_count++;
                end
                if (error !== want.error)
                begin
                    $error("error: expected %0b, got %0b", want.error, error);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < BUF_BYTES; i++)
            text_mem[i] = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: edges of the buffer, zero counts, spare codes
        push_edit(ACT_READ, 0, 0, 0);
        push_edit(ACT_INSERT, 0, 8'hFF, 0);
        push_edit(ACT_INSERT, 255, 8'hAA, 0);
        push_edit(ACT_READ, 0, 0, 254);
        push_edit(ACT_ADVANCE, 255, 0, 0);
        push_edit(ACT_ADVANCE, 255, 0, 0);
        push_edit(ACT_ADVANCE, 255, 0, 0);
        push_edit(ACT_INSERT, 8, 8'hFF, 0);       // runs off the end
        push_edit(ACT_SWAP, 0, 0, 0);             // cursor at the end
        push_edit(ACT_BACKUP, 1, 0, 0);
        push_edit(ACT_SWAP, 0, 0, 0);             // no byte after the cursor
        push_edit(ACT_BACKUP, 1, 0, 0);
        push_edit(ACT_SWAP, 0, 0, 0);
        push_edit(ACT_ADVANCE, 255, 0, 0);        // saturates at the end
        push_edit(ACT_READ, 0, 0, 1023);
        push_edit(ACT_DELETE, 255, 8'h00, 0);
        push_edit(ACT_BACKUP, 255, 0, 0);
        push_edit(ACT_BACKUP, 255, 0, 0);
        push_edit(ACT_BACKUP, 255, 0, 0);
        push_edit(ACT_BACKUP, 255, 0, 0);         // saturates at zero
        push_edit(ACT_DELETE, 1, 0, 0);           // nothing left to delete
        push_edit(ACT_ADVANCE, 0, 0, 0);
        push_edit(ACT_BACKUP, 0, 0, 0);
        push_edit(ACT_DELETE, 0, 0, 0);
        push_edit(ACT_SPARE6, 255, 8'hFF, 1023);
        push_edit(ACT_SPARE7, 255, 8'hFF, 1023);
        push_edit(ACT_READ, 0, 0, 10'h2AA);
        wait_drained();

        for (int i = 0; i < 500; i++)
            push_random_edit();
        // Sender pauses here until every result is back
        wait_drained();

        // Receiver holds off while the sender keeps offering
        stall_requests++;
        for (int i = 0; i < 400; i++)
            push_random_edit();
        wait_drained();

        // Back-to-back stretch with no idling
        idle_on = 1'b0;
        for (int i = 0; i < 250; i++)
            push_random_edit();
        wait_drained();

        idle_on = 1'b1;
        for (int i = 0; i < 300; i++)
            push_random_edit();
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
